### src/wfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_pkg: shared types and constants of the weighted fair slot admission
// Widths, command and status codes, config register indexes, sequencer ops.
// ---------------------------------------------------------------------------
package wfsa_pkg;

  localparam int GROUP_COUNT = 3;
  localparam int QUEUE_DEPTH = 16;

  localparam int GW   = 2;                         // group field width
  localparam int CW   = 10;                        // slot count width
  localparam int WW   = 16;                        // weight width
  localparam int TW   = 64;                        // waiter tag width
  localparam int NW   = 32;                        // tick counter width
  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = GROUP_COUNT * QUEUE_DEPTH;
  localparam int MAW  = $clog2(MEM_DEPTH);
  localparam int DW   = WW + 2;                    // summed weight width
  localparam int P1W  = CW + 1 + DW;               // (held+1) * denom
  localparam int P2W  = CW + WW;                   // total * weight
  localparam int DAW  = CW + DW;                   // held * wsum
  localparam int DVW  = DAW + 1;                   // signed deviation
  localparam int SUMW = CW + 3;                    // slot sums

  localparam logic [CW-1:0] HELD_MAX = {CW{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_PROD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_CONS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_DFLT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R_PROD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_R_CONS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_R_DFLT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 3'd7;

  // commands
  localparam logic [1:0] CMD_ADMIT   = 2'd0;
  localparam logic [1:0] CMD_TRY     = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // result status
  localparam logic [2:0] ST_RES_GRANT = 3'd0;
  localparam logic [2:0] ST_SH_GRANT  = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_REFUSED   = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_DISPATCH  = 3'd5;
  localparam logic [2:0] ST_TICK      = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXPIRE,
    OP_TICK,
    OP_MUL,
    OP_DECIDE,
    OP_RELEASE,
    OP_FLOOR_EV,
    OP_DEV_MUL,
    OP_DEV_EV,
    OP_PICK,
    OP_POP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic grp_bad;
    logic is_admit;
    logic rel_res_pop;
    logic rel_shared;
    logic idx_last;
    logic pick_found;
  } dp_stat_t;

endpackage
`default_nettype wire

### src/weighted_fair_slot_admission.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// weighted_fair_slot_admission: weighted fair share slot admission control
// Admits, queues, releases and dispatches slots for three weighted groups.
// ---------------------------------------------------------------------------
// channel   dir  beat fields (lowest bit first)
// s_axis    in   command[1:0], group[3:2]
// m_axis    out  status[2:0], dispatch_group[4:3], waiter_tag[68:5]
// cfg       in   cfg_idx_i selects register, cfg_data_i value
//
// One command at a time: a tick, an admit, a release with no scan, a release
// with a reserved dispatch, or a release with the three-group dispatch scan
// (one ring read and one deviation multiply per group), whether or not the
// scan dispatches. A finished beat sits in the output register; the next
// command is taken while it waits.
// Reset is asynchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module weighted_fair_slot_admission (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // command, group
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [71:0]                          m_axis_tdata,  // status, dispatch_group, waiter_tag
  input  wire logic                            cfg_we_i,
  input  wire logic [wfsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wfsa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wfsa_pkg::*;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [2:0]    status;
  logic [GW-1:0] dgrp;
  logic [TW-1:0] tag;

  wfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wfsa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tdata[1:0]),
    .in_grp_i     (s_axis_tdata[3:2]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status_o (status),
    .out_dgrp_o   (dgrp),
    .out_tag_o    (tag)
  );

  assign m_axis_tdata = {3'b000, tag, dgrp, status};

endmodule
`default_nettype wire

### src/wfsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_ctrl: command sequencer
// Walks one command through expiry, tick, grant decision, release and dispatch scan.
// ---------------------------------------------------------------------------
module wfsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire wfsa_pkg::dp_stat_t stat_i,
  output wfsa_pkg::dp_cmd_t      cmd_o
);
  import wfsa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXP  = 4'd1;
  localparam logic [3:0] S_TICK = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_REL  = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FEV  = 4'd7;
  localparam logic [3:0] S_DMUL = 4'd8;
  localparam logic [3:0] S_DEV  = 4'd9;
  localparam logic [3:0] S_PICK = 4'd10;
  localparam logic [3:0] S_PRD  = 4'd11;
  localparam logic [3:0] S_POP  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // next state and datapath op
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_EXP;
        end
      end
      S_EXP: begin
        cmd_o.op = OP_EXPIRE;
        if (stat_i.is_tick)       state_d = S_TICK;
        else if (stat_i.grp_bad)  state_d = S_DONE;
        else if (stat_i.is_admit) state_d = S_MUL;
        else                      state_d = S_REL;
      end
      S_TICK: begin
        cmd_o.op = OP_TICK;
        state_d  = S_DONE;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_DEC;
      end
      S_DEC: begin
        cmd_o.op = OP_DECIDE;
        state_d  = S_DONE;
      end
      S_REL: begin
        cmd_o.op = OP_RELEASE;
        if (stat_i.rel_res_pop)     state_d = S_PRD;
        else if (stat_i.rel_shared) state_d = S_FRD;
        else                        state_d = S_DONE;
      end
      S_FRD: state_d = S_FEV;
      S_FEV: begin
        cmd_o.op = OP_FLOOR_EV;
        state_d  = stat_i.idx_last ? S_DMUL : S_FRD;
      end
      S_DMUL: begin
        cmd_o.op = OP_DEV_MUL;
        state_d  = S_DEV;
      end
      S_DEV: begin
        cmd_o.op = OP_DEV_EV;
        state_d  = stat_i.idx_last ? S_PICK : S_DMUL;
      end
      S_PICK: begin
        cmd_o.op = OP_PICK;
        state_d  = stat_i.pick_found ? S_PRD : S_DONE;
      end
      S_PRD: state_d = S_POP;
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // result register free or draining this cycle
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = OP_EMIT;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

### src/wfsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_dp: admission datapath
// Config registers, per-group counters, waiter rings and the result register.
// ---------------------------------------------------------------------------
module wfsa_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [wfsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wfsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]                      in_cmd_i,
  input  wire logic [wfsa_pkg::GW-1:0]         in_grp_i,
  input  wire wfsa_pkg::dp_cmd_t               cmd_i,
  output wfsa_pkg::dp_stat_t                   stat_o,
  output logic [2:0]                           out_status_o,
  output logic [wfsa_pkg::GW-1:0]              out_dgrp_o,
  output logic [wfsa_pkg::TW-1:0]              out_tag_o
);
  import wfsa_pkg::*;

  localparam int TSW = FW + 1;

  // configuration
  logic [CW-1:0] total_q;
  logic [WW-1:0] weight_q [GROUP_COUNT];
  logic [CW-1:0] rsv_q    [GROUP_COUNT];
  logic [WW-1:0] dwell_q;

  // state
  logic [NW-1:0]  now_q;
  logic [CW-1:0]  held_q   [GROUP_COUNT];
  logic [CW-1:0]  rheld_q  [GROUP_COUNT];
  logic [NW-1:0]  since_q  [GROUP_COUNT];
  logic           mark_q   [GROUP_COUNT];
  logic [QAW-1:0] head_q   [GROUP_COUNT];
  logic [FW-1:0]  fill_q   [GROUP_COUNT];
  logic [TW-1:0]  ntag_q;

  // command item and scratch
  logic [1:0]     cmd_q;
  logic [GW-1:0]  grp_q;
  logic [GW-1:0]  idx_q;
  logic [GW-1:0]  pick_q;
  logic           pop_rsv_q;
  logic [DW-1:0]  denom_q;
  logic [P1W-1:0] p1_q;
  logic [P2W-1:0] p2_q;
  logic [DW-1:0]  wsum_q;
  logic           floor_v_q;
  logic [GW-1:0]  floor_g_q;
  logic [TW-1:0]  oldest_q;
  logic           best_v_q;
  logic [GW-1:0]  best_g_q;
  logic [DVW-1:0] low_dev_q;
  logic [DAW-1:0] da_q;
  logic [P2W-1:0] db_q;
  logic           delig_q;

  // result staging and output register
  logic [2:0]     res_st_q;
  logic [GW-1:0]  res_dg_q;
  logic [TW-1:0]  res_tag_q;
  logic [2:0]     ost_q;
  logic [GW-1:0]  odg_q;
  logic [TW-1:0]  otag_q;

  // waiter rings
  logic [TW-1:0]  mem [MEM_DEPTH];
  logic [TW-1:0]  rdata_q;
  logic [MAW-1:0] raddr, waddr;
  logic           mem_we;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      dwell_q <= WW'(1);
      for (int i = 0; i < GROUP_COUNT; i++) begin
        weight_q[i] <= '0;
        rsv_q[i]    <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:  total_q     <= cfg_data_i[CW-1:0];
        CFG_W_PROD: weight_q[0] <= cfg_data_i[WW-1:0];
        CFG_W_CONS: weight_q[1] <= cfg_data_i[WW-1:0];
        CFG_W_DFLT: weight_q[2] <= cfg_data_i[WW-1:0];
        CFG_R_PROD: rsv_q[0]    <= cfg_data_i[CW-1:0];
        CFG_R_CONS: rsv_q[1]    <= cfg_data_i[CW-1:0];
        CFG_R_DFLT: rsv_q[2]    <= cfg_data_i[CW-1:0];
        CFG_DWELL:  dwell_q     <= cfg_data_i[WW-1:0];
        default: ;
      endcase
    end
  end

  // selected group, clamped so an invalid code indexes safely
  logic          grp_bad;
  logic [GW-1:0] gi;
  assign grp_bad = grp_q >= GW'(GROUP_COUNT);
  assign gi      = grp_bad ? '0 : grp_q;

  logic [CW-1:0] held_g, rheld_g, rsv_g;
  logic [FW-1:0] fill_g;
  assign held_g  = held_q[gi];
  assign rheld_g = rheld_q[gi];
  assign rsv_g   = rsv_q[gi];
  assign fill_g  = fill_q[gi];

  // activity and mark expiry
  logic [GROUP_COUNT-1:0] act, eff, exp_clr;
  always_comb begin
    for (int i = 0; i < GROUP_COUNT; i++) begin
      act[i]     = (held_q[i] != '0) || (fill_q[i] != '0);
      eff[i]     = act[i] || mark_q[i];
      exp_clr[i] = !act[i] && mark_q[i] &&
                   ((now_q - since_q[i]) >= NW'(dwell_q));
    end
  end

  // cap denominator: effectively active weights plus the requester
  logic [DW-1:0] denom_c;
  always_comb begin
    denom_c = '0;
    for (int i = 0; i < GROUP_COUNT; i++)
      if (eff[i] || (GW'(i) == gi)) denom_c = denom_c + DW'(weight_q[i]);
  end

  // pool sums
  logic [SUMW-1:0] rsv_sum, sh_held;
  always_comb begin
    rsv_sum = '0;
    sh_held = '0;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      rsv_sum = rsv_sum + SUMW'(rsv_q[i]);
      sh_held = sh_held + SUMW'(held_q[i] - rheld_q[i]);
    end
  end

  // grant decision
  logic cap_ok, hmax, g_res, g_sh, shared_ok, q_full;
  assign hmax      = held_g == HELD_MAX;
  assign shared_ok = SUMW'(total_q) > (rsv_sum + sh_held);
  assign cap_ok    = (denom_q == '0) ? (held_g < total_q)
                   : ((held_g == '0) || (p1_q <= P1W'(p2_q)));
  assign g_res     = !hmax && (rsv_g > rheld_g);
  assign g_sh      = !hmax && !g_res && ((held_g < rsv_g) || cap_ok) && shared_ok;
  assign q_full    = fill_g == FW'(QUEUE_DEPTH);

  // ring tail of the selected group
  logic [TSW-1:0] tsum;
  logic [QAW-1:0] tail;
  always_comb begin
    tsum = TSW'(head_q[gi]) + TSW'(fill_g);
    if (tsum >= TSW'(QUEUE_DEPTH)) tsum = tsum - TSW'(QUEUE_DEPTH);
    tail = QAW'(tsum);
  end

  // scan eligibility of the current index
  logic          elig_i, floor_take;
  logic [DVW-1:0] dev;
  assign elig_i     = (fill_q[idx_q] != '0) && (held_q[idx_q] != HELD_MAX);
  assign floor_take = elig_i && (held_q[idx_q] < rsv_q[idx_q]) &&
                      (!floor_v_q || (rdata_q < oldest_q));
  assign dev        = DVW'(da_q) - DVW'(db_q);

  // memory ports
  logic          rd_pick_q;
  logic          pick_valid_rd;
  logic [GW-1:0] rgrp;
  assign pick_valid_rd = rd_pick_q;
  assign rgrp   = (cmd_i.op == OP_NONE && pick_valid_rd) ? pick_q : idx_q;
  assign raddr  = MAW'(int'(rgrp) * QUEUE_DEPTH + int'(head_q[rgrp]));
  assign waddr  = MAW'(int'(gi) * QUEUE_DEPTH + int'(tail));
  assign mem_we = (cmd_i.op == OP_DECIDE) && !g_res && !g_sh &&
                  (cmd_q == CMD_ADMIT) && !q_full;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= ntag_q;
    rdata_q <= mem[raddr];
  end

  // sequenced state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      ntag_q    <= '0;
      rd_pick_q <= 1'b0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
        held_q[i]  <= '0;
        rheld_q[i] <= '0;
        since_q[i] <= '0;
        mark_q[i]  <= 1'b0;
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
      end
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          cmd_q     <= in_cmd_i;
          grp_q     <= in_grp_i;
          res_st_q  <= ST_REFUSED;
          res_dg_q  <= '0;
          res_tag_q <= '0;
          rd_pick_q <= 1'b0;
        end
        OP_EXPIRE: begin
          for (int i = 0; i < GROUP_COUNT; i++)
            if (exp_clr[i]) mark_q[i] <= 1'b0;
        end
        OP_TICK: begin
          now_q    <= now_q + NW'(1);
          res_st_q <= ST_TICK;
        end
        OP_MUL: begin
          denom_q <= denom_c;
          p1_q    <= P1W'(held_g + CW'(1)) * P1W'(denom_c) + P1W'(
                     (held_g == HELD_MAX) ? denom_c : '0);
          p2_q    <= P2W'(total_q) * P2W'(weight_q[gi]);
        end
        OP_DECIDE: begin
          if (g_res) begin
            held_q[gi]  <= held_g + CW'(1);
            rheld_q[gi] <= rheld_g + CW'(1);
            res_st_q    <= ST_RES_GRANT;
          end else if (g_sh) begin
            held_q[gi] <= held_g + CW'(1);
            res_st_q   <= ST_SH_GRANT;
          end else if (cmd_q == CMD_ADMIT) begin
            if (q_full) begin
              res_st_q <= ST_FULL;
            end else begin
              fill_q[gi] <= fill_g + FW'(1);
              ntag_q     <= ntag_q + TW'(1);
              res_tag_q  <= ntag_q;
              res_st_q   <= ST_QUEUED;
            end
          end
        end
        OP_RELEASE: begin
          res_st_q  <= ST_RELEASED;
          pick_q    <= gi;
          pop_rsv_q <= rheld_g != '0;
          rd_pick_q <= rheld_g != '0;
          idx_q     <= '0;
          wsum_q    <= '0;
          floor_v_q <= 1'b0;
          best_v_q  <= 1'b0;
          if (held_g != '0) begin
            held_q[gi] <= held_g - CW'(1);
            if (held_g == CW'(1) && fill_g == '0) begin
              since_q[gi] <= now_q;
              mark_q[gi]  <= 1'b1;
            end
            if (rheld_g != '0) rheld_q[gi] <= rheld_g - CW'(1);
          end
        end
        OP_FLOOR_EV: begin
          if (elig_i) wsum_q <= wsum_q + DW'(weight_q[idx_q]);
          if (floor_take) begin
            floor_v_q <= 1'b1;
            floor_g_q <= idx_q;
            oldest_q  <= rdata_q;
          end
          idx_q <= (idx_q == GW'(GROUP_COUNT - 1)) ? '0 : idx_q + GW'(1);
        end
        OP_DEV_MUL: begin
          da_q    <= DAW'(held_q[idx_q]) * DAW'(wsum_q);
          db_q    <= P2W'(total_q) * P2W'(weight_q[idx_q]);
          delig_q <= elig_i;
        end
        OP_DEV_EV: begin
          if (delig_q && (!best_v_q || ($signed(dev) < $signed(low_dev_q)))) begin
            best_v_q  <= 1'b1;
            best_g_q  <= idx_q;
            low_dev_q <= dev;
          end
          idx_q <= (idx_q == GW'(GROUP_COUNT - 1)) ? '0 : idx_q + GW'(1);
        end
        OP_PICK: begin
          pick_q    <= floor_v_q ? floor_g_q : best_g_q;
          rd_pick_q <= 1'b1;
        end
        OP_POP: begin
          held_q[pick_q] <= held_q[pick_q] + CW'(1);
          if (pop_rsv_q) rheld_q[pick_q] <= rheld_q[pick_q] + CW'(1);
          head_q[pick_q] <= (head_q[pick_q] == QAW'(QUEUE_DEPTH - 1)) ? '0
                          : head_q[pick_q] + QAW'(1);
          fill_q[pick_q] <= fill_q[pick_q] - FW'(1);
          res_tag_q      <= rdata_q;
          res_dg_q       <= pick_q;
          res_st_q       <= ST_DISPATCH;
          rd_pick_q      <= 1'b0;
        end
        OP_EMIT: begin
          ost_q  <= res_st_q;
          odg_q  <= res_dg_q;
          otag_q <= res_tag_q;
        end
        default: ;
      endcase
    end
  end

  // status toward the sequencer
  assign stat_o.is_tick     = cmd_q == CMD_TICK;
  assign stat_o.grp_bad     = grp_bad;
  assign stat_o.is_admit    = (cmd_q == CMD_ADMIT) || (cmd_q == CMD_TRY);
  assign stat_o.rel_res_pop = (held_g != '0) && (rheld_g != '0) && (fill_g != '0);
  assign stat_o.rel_shared  = (held_g != '0) && (rheld_g == '0);
  assign stat_o.idx_last    = idx_q == GW'(GROUP_COUNT - 1);
  assign stat_o.pick_found  = floor_v_q || best_v_q;

  assign out_status_o = ost_q;
  assign out_dgrp_o   = odg_q;
  assign out_tag_o    = otag_q;

endmodule
`default_nettype wire

### tb/weighted_fair_slot_admission_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_fair_slot_admission_tb: self-checking bench of the slot admission
// Drives admit, try, release and tick beats under several register settings
// and idle patterns. Every result beat is checked against an in-bench model, or against the row's given result.
// ---------------------------------------------------------------------------
module weighted_fair_slot_admission_tb;
  import wfsa_pkg::*;

  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic [2:0]    st;
    logic [GW-1:0] dg;
    logic [TW-1:0] tag;
  } slot_result_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [GW-1:0] grp;
    logic          known;
    slot_result_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;     // command[1:0], group[3:2]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // status[2:0], dispatch_group[4:3], waiter_tag[68:5]
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  weighted_fair_slot_admission dut (.*);

  always #5 clk_i = ~clk_i;

  // model state: registers
  int unsigned capacity_r, dwell_r;
  int unsigned weight_r [GROUP_COUNT];
  int unsigned reserve_r [GROUP_COUNT];
  // model state: admission bookkeeping
  logic [NW-1:0] tick_now;
  int unsigned held_q [GROUP_COUNT];
  int unsigned res_held_q [GROUP_COUNT];
  logic [NW-1:0] idle_at [GROUP_COUNT];
  bit idle_marked [GROUP_COUNT];
  logic [TW-1:0] waiters [GROUP_COUNT][QUEUE_DEPTH];
  int unsigned ring_head [GROUP_COUNT];
  int unsigned ring_fill [GROUP_COUNT];
  logic [TW-1:0] tag_next;

  // expected beats in flight
  slot_result_t exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  bit failed = 1'b0;
  int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
  bit row_known = 1'b0;
  slot_result_t row_res = '0;
  int quiet_cycles = 0;

  function automatic bit grp_busy(int g);
    return held_q[g] > 0 || ring_fill[g] > 0;
  endfunction

  function automatic bit grp_counts(int g);
    return grp_busy(g) || idle_marked[g];
  endfunction

  function automatic longint shared_left();
    longint v = capacity_r;
    for (int g = 0; g < GROUP_COUNT; g++)
      v -= longint'(reserve_r[g]) + longint'(held_q[g]) - longint'(res_held_q[g]);
    return v;
  endfunction

  function automatic logic [TW-1:0] ring_front(int g);
    return waiters[g][ring_head[g] % QUEUE_DEPTH];
  endfunction

  function automatic logic [TW-1:0] ring_pop(int g);
    logic [TW-1:0] t = ring_front(g);
    ring_head[g] = (ring_head[g] + 1) % QUEUE_DEPTH;
    ring_fill[g]--;
    return t;
  endfunction

  function automatic logic [2:0] grant_slot(int g);
    longint denom = 0;
    longint cap;
    if (held_q[g] >= HELD_MAX) return ST_REFUSED;
    for (int i = 0; i < GROUP_COUNT; i++)
      if (grp_counts(i)) denom += weight_r[i];
    if (!grp_counts(g)) denom += weight_r[g];
    if (denom > 0) begin
      cap = (longint'(capacity_r) * longint'(weight_r[g])) / denom;
      if (cap < 1) cap = 1;
    end else begin
      cap = capacity_r;
    end
    // reserved pool first, cap ignored
    if (reserve_r[g] > 0 && longint'(reserve_r[g]) - longint'(res_held_q[g]) >= 1) begin
      held_q[g]++;
      res_held_q[g]++;
      return ST_RES_GRANT;
    end
    if ((held_q[g] < reserve_r[g] || longint'(held_q[g]) < cap) && shared_left() >= 1) begin
      held_q[g]++;
      return ST_SH_GRANT;
    end
    return ST_REFUSED;
  endfunction

  // shared slot goes to floor group by oldest tag, else least deviation
  function automatic int pick_waiting_group();
    int floor_g = GROUP_COUNT, best_g = GROUP_COUNT;
    logic [TW-1:0] oldest = '0;
    longint wsum = 0, min_dev = 0, dev;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      if (ring_fill[g] == 0 || held_q[g] >= HELD_MAX) continue;
      wsum += weight_r[g];
      if (held_q[g] < reserve_r[g] &&
          (floor_g == GROUP_COUNT || ring_front(g) < oldest)) begin
        oldest = ring_front(g);
        floor_g = g;
      end
    end
    if (floor_g != GROUP_COUNT) return floor_g;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      if (ring_fill[g] == 0 || held_q[g] >= HELD_MAX) continue;
      dev = longint'(held_q[g]) * wsum - longint'(capacity_r) * longint'(weight_r[g]);
      if (best_g == GROUP_COUNT || dev < min_dev) begin
        min_dev = dev;
        best_g = g;
      end
    end
    return best_g;
  endfunction

  function automatic slot_result_t admission_step(logic [1:0] cmd, logic [GW-1:0] gsel);
    slot_result_t r = '{st: ST_REFUSED, dg: '0, tag: '0};
    int g = gsel;
    int pick;
    // expire idle marks past the dwell window
    for (int i = 0; i < GROUP_COUNT; i++)
      if (!grp_busy(i) && idle_marked[i] && (tick_now - idle_at[i]) >= dwell_r)
        idle_marked[i] = 1'b0;
    if (cmd == CMD_TICK) begin
      tick_now++;
      r.st = ST_TICK;
    end else if (g < GROUP_COUNT) begin
      if (cmd == CMD_ADMIT || cmd == CMD_TRY) begin
        r.st = grant_slot(g);
        if (r.st == ST_REFUSED && cmd == CMD_ADMIT) begin
          if (ring_fill[g] >= QUEUE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            r.tag = tag_next++;
            waiters[g][(ring_head[g] + ring_fill[g]) % QUEUE_DEPTH] = r.tag;
            ring_fill[g]++;
            r.st = ST_QUEUED;
          end
        end
      end else if (held_q[g] == 0) begin
        r.st = ST_RELEASED;
      end else begin
        held_q[g]--;
        if (!grp_busy(g)) begin
          idle_at[g] = tick_now;
          idle_marked[g] = 1'b1;
        end
        r.st = ST_RELEASED;
        if (res_held_q[g] > 0) begin
          // reserved slot stays in the group if it has a waiter
          res_held_q[g]--;
          if (ring_fill[g] > 0) begin
            r.tag = ring_pop(g);
            held_q[g]++;
            res_held_q[g]++;
            r.dg = GW'(g);
            r.st = ST_DISPATCH;
          end
        end else begin
          pick = pick_waiting_group();
          if (pick < GROUP_COUNT) begin
            r.tag = ring_pop(pick);
            held_q[pick]++;
            r.dg = GW'(pick);
            r.st = ST_DISPATCH;
          end
        end
      end
    end
    return r;
  endfunction

  // beat monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    slot_result_t got, want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        want = admission_step(s_axis_tdata[1:0], s_axis_tdata[3:2]);
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
          $display("%0t: too many beats in flight", $time);
          failed = 1'b1;
        end
        exp_fifo[exp_wr % EXP_DEPTH] = row_known ? row_res : want;
        exp_wr++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.st  = m_axis_tdata[2:0];
        got.dg  = m_axis_tdata[4:3];
        got.tag = m_axis_tdata[68:5];
        if (exp_wr == exp_rd) begin
          $display("%0t: result beat with none expected: status %0d group %0d tag %0h",
                   $time, got.st, got.dg, got.tag);
          failed = 1'b1;
        end else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            failed = 1'b1;
          end
          if (got.dg !== want.dg) begin
            $display("%0t: dispatch group expected %0d actual %0d", $time, want.dg, got.dg);
            failed = 1'b1;
          end
          if (got.tag !== want.tag) begin
            $display("%0t: tag expected %0h actual %0h", $time, want.tag, got.tag);
            failed = 1'b1;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 45);
    else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 6);
    else m_axis_tready <= 1'b1;
  end

  task automatic send_beat(logic [1:0] cmd, logic [GW-1:0] grp, bit known,
                           slot_result_t res);
    int pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 6 : 0;
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    row_known = known;
    row_res = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, grp, cmd};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    row_known = 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TOTAL:  capacity_r = val & 10'h3ff;
      CFG_W_PROD: weight_r[0] = val & 16'hffff;
      CFG_W_CONS: weight_r[1] = val & 16'hffff;
      CFG_W_DFLT: weight_r[2] = val & 16'hffff;
      CFG_R_PROD: reserve_r[0] = val & 10'h3ff;
      CFG_R_CONS: reserve_r[1] = val & 10'h3ff;
      CFG_R_DFLT: reserve_r[2] = val & 10'h3ff;
      CFG_DWELL:  dwell_r = val & 16'hffff;
      default: ;
    endcase
  endtask

  task automatic run_rows(stim_row_t rows[]);
    foreach (rows[i]) begin
      send_beat(rows[i].cmd, rows[i].grp, rows[i].known, rows[i].res);
    end
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(3))
      0: return 0;
      1: return 1;
      2: return 16'hffff;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  initial begin
    stim_row_t fresh_rows[];
    stim_row_t setup_rows[];
    int unsigned r;
    capacity_r = 0;
    dwell_r = 1;
    tick_now = '0;
    tag_next = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      weight_r[g] = 0; reserve_r[g] = 0; held_q[g] = 0; res_held_q[g] = 0;
      idle_at[g] = '0; idle_marked[g] = 1'b0; ring_head[g] = 0; ring_fill[g] = 0;
    end

    // after reset: no capacity, so admits queue and try admits are refused
    fresh_rows = '{
      '{CMD_ADMIT,   2'd0, 1'b1, '{ST_QUEUED,   2'd0, 64'd0}},
      '{CMD_TRY,     2'd1, 1'b1, '{ST_REFUSED,  2'd0, 64'd0}},
      '{CMD_RELEASE, 2'd2, 1'b1, '{ST_RELEASED, 2'd0, 64'd0}},
      '{CMD_ADMIT,   2'd3, 1'b1, '{ST_REFUSED,  2'd0, 64'd0}},
      '{CMD_RELEASE, 2'd3, 1'b1, '{ST_REFUSED,  2'd0, 64'd0}},
      '{CMD_TICK,    2'd3, 1'b1, '{ST_TICK,     2'd0, 64'd0}},
      '{CMD_ADMIT,   2'd1, 1'b1, '{ST_QUEUED,   2'd0, 64'd1}}
    };
    // small pool: reserved grant, shared grants, queuing, both dispatch kinds
    setup_rows = '{
      '{CMD_ADMIT,   2'd0, 1'b0, '0}, '{CMD_ADMIT,   2'd0, 1'b0, '0},
      '{CMD_TRY,     2'd1, 1'b0, '0}, '{CMD_ADMIT,   2'd1, 1'b0, '0},
      '{CMD_ADMIT,   2'd2, 1'b0, '0}, '{CMD_ADMIT,   2'd2, 1'b0, '0},
      '{CMD_ADMIT,   2'd0, 1'b0, '0}, '{CMD_TRY,     2'd2, 1'b0, '0},
      '{CMD_RELEASE, 2'd0, 1'b0, '0}, '{CMD_RELEASE, 2'd1, 1'b0, '0},
      '{CMD_RELEASE, 2'd2, 1'b0, '0}, '{CMD_TICK,    2'd0, 1'b0, '0},
      '{CMD_TICK,    2'd2, 1'b0, '0}, '{CMD_RELEASE, 2'd0, 1'b0, '0},
      '{CMD_TRY,     2'd3, 1'b0, '0}, '{CMD_TICK,    2'd1, 1'b0, '0},
      '{CMD_RELEASE, 2'd1, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_rows(fresh_rows);
    drain();
    write_reg(CFG_TOTAL, 4);
    write_reg(CFG_W_PROD, 1);
    write_reg(CFG_W_CONS, 2);
    write_reg(CFG_W_DFLT, 3);
    write_reg(CFG_R_PROD, 1);
    write_reg(CFG_R_CONS, 0);
    write_reg(CFG_R_DFLT, 0);
    write_reg(CFG_DWELL, 2);
    run_rows(setup_rows);
    drain();

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < 8; p++) begin
      idle_mode = p % 4;
      write_reg(CFG_TOTAL, (p == 2) ? 1023 : (p == 5) ? 0 : $urandom_range(2, 16));
      write_reg(CFG_W_PROD, pick_weight());
      write_reg(CFG_W_CONS, pick_weight());
      write_reg(CFG_W_DFLT, pick_weight());
      write_reg(CFG_R_PROD, (p == 6) ? 1023 : $urandom_range(0, 3));
      write_reg(CFG_R_CONS, $urandom_range(0, 3));
      write_reg(CFG_R_DFLT, (p == 3) ? 0 : $urandom_range(0, 2));
      write_reg(CFG_DWELL, (p == 4) ? 16'hffff : (p == 7) ? 1 : $urandom_range(1, 4));
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(99);
        send_beat(r < 40 ? CMD_ADMIT : r < 55 ? CMD_TRY : r < 85 ? CMD_RELEASE : CMD_TICK,
                  ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(0, 2)), 1'b0, '0);
      end
      drain();
    end

    // fill the producer group up to its held counter limit
    idle_mode = 0;
    write_reg(CFG_TOTAL, 1023);
    write_reg(CFG_R_PROD, 1023);
    write_reg(CFG_W_PROD, 16'hffff);
    for (int n = 0; n < 1040; n++)
      send_beat(($urandom_range(9) == 0) ? CMD_TRY : CMD_ADMIT, 2'd0, 1'b0, '0);
    for (int n = 0; n < 20; n++) begin
      r = $urandom_range(2);
      send_beat(r == 0 ? CMD_RELEASE : r == 1 ? CMD_ADMIT : CMD_TRY,
                2'($urandom_range(0, 2)), 1'b0, '0);
    end
    drain();

    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/wfsa_pkg.sv
src/wfsa_ctrl.sv
src/wfsa_dp.sv
src/weighted_fair_slot_admission.sv
tb/weighted_fair_slot_admission_tb.sv
